@@ hw/rtl/tcr_pkg.sv @@
// tcr_pkg: constants, field widths, command and register codes for the text cell
// row rasterizer. No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps
package tcr_pkg;

  localparam int GLYPH_COLS        = 8;
  localparam int GLYPH_ROWS        = 12;
  localparam int GLYPH_STORE_DEPTH = 4096;
  localparam int PALETTE_SIZE      = 16;

  localparam int GLYPH_AW   = $clog2(GLYPH_STORE_DEPTH);
  localparam int PAL_AW     = $clog2(PALETTE_SIZE);
  localparam int PIX_CNT_W  = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
  localparam int GLYPH_W    = 8;
  localparam int COLOR_W    = 16;

  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int CIDX_W     = 4;
  localparam int POS_W      = 6;
  localparam int ROW_W      = 4;
  localparam int LADDR_W    = 12;
  localparam int LVAL_W     = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CODE_W-1:0] FIRST_CODE_RST = 8'd32;
  localparam logic [CODE_W-1:0] LAST_CODE_RST  = 8'd127;

  localparam logic [GLYPH_W-1:0] ROW_FULL  = 8'hFF;
  localparam logic [GLYPH_W-1:0] ROW_EMPTY = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_RENDER     = 2'd0,
    CMD_LOAD_GLYPH = 2'd1,
    CMD_LOAD_PAL   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_CODE     = 3'd0,
    CFG_LAST_CODE      = 3'd1,
    CFG_CURSOR_VISIBLE = 3'd2,
    CFG_CURSOR_COLUMN  = 3'd3,
    CFG_CURSOR_LINE    = 3'd4,
    CFG_BLINK_PHASE    = 3'd5
  } cfg_idx_t;

endpackage

@@ hw/rtl/tcr_in_if.sv @@
// tcr_in_if: valid/ready channel carrying render and load items into the core.
// Depends on tcr_pkg for field widths.
`timescale 1ns / 1ps
interface tcr_in_if;
  import tcr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [CODE_W-1:0]   char_code;
  logic [CIDX_W-1:0]   fg_index;
  logic [CIDX_W-1:0]   bg_index;
  logic                bold;
  logic                underline;
  logic                blink;
  logic [POS_W-1:0]    column;
  logic [POS_W-1:0]    line;
  logic [ROW_W-1:0]    row_in_cell;
  logic [LADDR_W-1:0]  load_address;
  logic [LVAL_W-1:0]   load_value;

  modport source (
    output valid, cmd, char_code, fg_index, bg_index, bold, underline, blink,
           column, line, row_in_cell, load_address, load_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, char_code, fg_index, bg_index, bold, underline, blink,
           column, line, row_in_cell, load_address, load_value,
    output ready
  );
endinterface

@@ hw/rtl/tcr_out_if.sv @@
// tcr_out_if: valid/ready channel carrying RGB565 pixels out of the core.
// Depends on tcr_pkg for field widths.
`timescale 1ns / 1ps
interface tcr_out_if;
  import tcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel;
  logic               last_pixel;

  modport source (output valid, pixel, last_pixel, input ready);
  modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

@@ hw/rtl/text_cell_row_rasterizer_core.sv @@
// text_cell_row_rasterizer_core: an accepted render transaction is registered in
// the read stage, then in the pixel serializer, which sends GLYPH_COLS pixels, one
// per cycle while out_chan is ready. The read stage can accept a new render while
// the serializer still sends the last one. Reset (rst_n, synchronous) restores the
// config and valid registers; glyph store and palette are undefined until written.
// Depends on tcr_pkg, tcr_in_if and tcr_out_if.
`timescale 1ns / 1ps
module text_cell_row_rasterizer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tcr_in_if.sink                         in_chan,
  tcr_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcr_pkg::*;

  // configuration
  logic [CODE_W-1:0] first_code_r, last_code_r;
  logic              cursor_visible_r, blink_phase_r;
  logic [POS_W-1:0]  cursor_column_r, cursor_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r     <= FIRST_CODE_RST;
      last_code_r      <= LAST_CODE_RST;
      cursor_visible_r <= 1'b0;
      cursor_column_r  <= '0;
      cursor_line_r    <= '0;
      blink_phase_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_CODE:     first_code_r     <= cfg_wdata[CODE_W-1:0];
        CFG_LAST_CODE:      last_code_r      <= cfg_wdata[CODE_W-1:0];
        CFG_CURSOR_VISIBLE: cursor_visible_r <= cfg_wdata[0];
        CFG_CURSOR_COLUMN:  cursor_column_r  <= cfg_wdata[POS_W-1:0];
        CFG_CURSOR_LINE:    cursor_line_r    <= cfg_wdata[POS_W-1:0];
        CFG_BLINK_PHASE:    blink_phase_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic in_fire, is_render, is_load_glyph, is_load_pal;
  logic s1_v_r, s1_adv, ser_free;
  logic ser_v_r;
  logic [PIX_CNT_W-1:0] ser_cnt_r;
  logic out_fire, ser_last;

  assign ser_last  = (ser_cnt_r == PIX_CNT_W'(GLYPH_COLS - 1));
  assign out_fire  = out_chan.valid && out_chan.ready;
  assign ser_free  = !ser_v_r || (out_fire && ser_last);
  assign s1_adv    = s1_v_r && ser_free;
  assign in_chan.ready = !s1_v_r || s1_adv;
  assign in_fire   = in_chan.valid && in_chan.ready;

  assign is_render     = in_fire && (in_chan.cmd == CMD_RENDER);
  assign is_load_glyph = in_fire && (in_chan.cmd == CMD_LOAD_GLYPH) &&
                         ({1'b0, in_chan.load_address} < (LADDR_W+1)'(GLYPH_STORE_DEPTH));
  assign is_load_pal   = in_fire && (in_chan.cmd == CMD_LOAD_PAL) &&
                         ({1'b0, in_chan.load_address} < (LADDR_W+1)'(PALETTE_SIZE));

  // item decode
  logic [CODE_W-1:0]   code_diff;
  logic [GLYPH_AW-1:0] glyph_addr;
  logic [PAL_AW-1:0]   fg_addr, bg_addr;
  logic                code_ok, at_cursor, row_beyond, fill_row, uline_row, use_glyph;
  logic [GLYPH_W-1:0]  force_bits;

  always_comb begin
    code_diff  = in_chan.char_code - first_code_r;
    glyph_addr = GLYPH_AW'(code_diff) * GLYPH_AW'(GLYPH_ROWS) + GLYPH_AW'(in_chan.row_in_cell);
    fg_addr    = PAL_AW'(in_chan.fg_index % PALETTE_SIZE);
    bg_addr    = PAL_AW'(in_chan.bg_index % PALETTE_SIZE);
    code_ok    = (in_chan.char_code >= first_code_r) && (in_chan.char_code <= last_code_r);
    at_cursor  = cursor_visible_r && (in_chan.column == cursor_column_r) &&
                 (in_chan.line == cursor_line_r);
    row_beyond = ({1'b0, in_chan.row_in_cell} >= (ROW_W+1)'(GLYPH_ROWS));
    fill_row   = !code_ok || (blink_phase_r && (in_chan.blink || at_cursor));
    uline_row  = in_chan.underline && (in_chan.row_in_cell == ROW_W'(GLYPH_ROWS - 1));
    use_glyph  = 1'b0;
    if (row_beyond) begin
      force_bits = ROW_EMPTY;
    end else if (fill_row) begin
      force_bits = at_cursor ? ROW_FULL : ROW_EMPTY;
    end else if (uline_row) begin
      force_bits = ROW_FULL;
    end else begin
      force_bits = ROW_EMPTY;
      use_glyph  = 1'b1;
    end
  end

  // glyph store and palette; read data holds until the next render transaction
  logic [GLYPH_W-1:0] glyph_mem [GLYPH_STORE_DEPTH];
  logic [COLOR_W-1:0] pal_mem   [PALETTE_SIZE];
  logic [GLYPH_W-1:0] glyph_q_r;
  logic [COLOR_W-1:0] fg_q_r, bg_q_r;

  always_ff @(posedge clk) begin
    if (is_load_glyph) begin
      glyph_mem[in_chan.load_address[GLYPH_AW-1:0]] <= in_chan.load_value[GLYPH_W-1:0];
    end
    if (is_render) begin
      glyph_q_r <= glyph_mem[glyph_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_load_pal) begin
      pal_mem[in_chan.load_address[PAL_AW-1:0]] <= in_chan.load_value;
    end
    if (is_render) begin
      fg_q_r <= pal_mem[fg_addr];
      bg_q_r <= pal_mem[bg_addr];
    end
  end

  // read stage
  logic               use_glyph_r, bold_r;
  logic [GLYPH_W-1:0] force_bits_r;
  logic               s1_v_nxt;
  logic [GLYPH_W-1:0] row_bits;

  assign s1_v_nxt = is_render || (s1_v_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_render) begin
      use_glyph_r  <= use_glyph;
      bold_r       <= in_chan.bold;
      force_bits_r <= force_bits;
    end
  end

  always_comb begin
    if (use_glyph_r) begin
      row_bits = bold_r ? (glyph_q_r | (glyph_q_r >> 1)) : glyph_q_r;
    end else begin
      row_bits = force_bits_r;
    end
  end

  // pixel serializer
  logic [GLYPH_W-1:0] ser_bits_r;
  logic [COLOR_W-1:0] ser_fg_r, ser_bg_r;
  logic               ser_v_nxt;

  always_comb begin
    if (s1_adv) begin
      ser_v_nxt = 1'b1;
    end else if (out_fire && ser_last) begin
      ser_v_nxt = 1'b0;
    end else begin
      ser_v_nxt = ser_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_cnt_r <= '0;
    end else begin
      ser_v_r <= ser_v_nxt;
      if (s1_adv) begin
        ser_cnt_r <= '0;
      end else if (out_fire) begin
        ser_cnt_r <= ser_cnt_r + PIX_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ser_bits_r <= row_bits;
      ser_fg_r   <= fg_q_r;
      ser_bg_r   <= bg_q_r;
    end else if (out_fire) begin
      ser_bits_r <= ser_bits_r << 1;
    end
  end

  assign out_chan.valid      = ser_v_r;
  assign out_chan.pixel      = ser_bits_r[GLYPH_W-1] ? ser_fg_r : ser_bg_r;
  assign out_chan.last_pixel = ser_last;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r)
    else $error("read stage dropped a stalled transaction");

  a_ser_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> ser_v_r && (ser_cnt_r == '0))
    else $error("serializer not restarted on load");

  a_ser_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && ser_last && !s1_adv |=> !ser_v_r)
    else $error("serializer still busy after last pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_v_r && ser_v_r)
    else $error("input stalled with a free pipeline");
`endif

endmodule

@@ dv/tb_text_cell_row_rasterizer_core.sv @@
// Self-checking testbench for text_cell_row_rasterizer_core: directed and random render, glyph
// and palette transactions with a built-in pixel predictor, random input gaps and output stalls.
// Depends on tcr_pkg, tcr_in_if, tcr_out_if and the core RTL.
`timescale 1ns / 1ps
module tb_text_cell_row_rasterizer_core;
  import tcr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 50;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CODE_W-1:0]  char_code;
    logic [CIDX_W-1:0]  fg_index;
    logic [CIDX_W-1:0]  bg_index;
    logic               bold;
    logic               underline;
    logic               blink;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   line;
    logic [ROW_W-1:0]   row_in_cell;
    logic [LADDR_W-1:0] load_address;
    logic [LVAL_W-1:0]  load_value;
  } cell_txn_t;

  typedef struct {
    logic [COLOR_W-1:0] pixel;
    logic               last_pixel;
  } pixel_exp_t;

  typedef enum {SRC_BEYOND, SRC_FILL, SRC_UNDERLINE, SRC_GLYPH} row_src_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcr_in_if  in_chan ();
  tcr_out_if out_chan ();

  text_cell_row_rasterizer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [GLYPH_W-1:0] glyph_mem     [GLYPH_STORE_DEPTH];
  bit                 glyph_written [GLYPH_STORE_DEPTH];
  logic [COLOR_W-1:0] pal_mem       [PALETTE_SIZE];
  bit                 pal_written   [PALETTE_SIZE];

  logic [CODE_W-1:0] reg_first_code  = FIRST_CODE_RST;
  logic [CODE_W-1:0] reg_last_code   = LAST_CODE_RST;
  logic              reg_cursor_on   = 1'b0;
  logic [POS_W-1:0]  reg_cursor_col  = '0;
  logic [POS_W-1:0]  reg_cursor_line = '0;
  logic              reg_blink_phase = 1'b0;

  pixel_exp_t expected_pixels[$];
  int         mismatches = 0;
  bit         idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  function automatic bit at_cursor(cell_txn_t t);
    return reg_cursor_on && t.column == reg_cursor_col && t.line == reg_cursor_line;
  endfunction

  function automatic row_src_t row_source(cell_txn_t t);
    bit in_window;
    in_window = t.char_code >= reg_first_code && t.char_code <= reg_last_code;
    if (t.row_in_cell >= GLYPH_ROWS) return SRC_BEYOND;
    if (!in_window || (reg_blink_phase && (t.blink || at_cursor(t)))) return SRC_FILL;
    if (t.underline && t.row_in_cell == GLYPH_ROWS - 1) return SRC_UNDERLINE;
    return SRC_GLYPH;
  endfunction

  function automatic int glyph_addr(cell_txn_t t);
    return ((int'(t.char_code) - int'(reg_first_code)) * GLYPH_ROWS + int'(t.row_in_cell))
           % GLYPH_STORE_DEPTH;
  endfunction

  function automatic void predict_row(cell_txn_t t);
    logic [GLYPH_W-1:0] bits;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    pixel_exp_t         e;
    fg = pal_mem[t.fg_index % PALETTE_SIZE];
    bg = pal_mem[t.bg_index % PALETTE_SIZE];
    case (row_source(t))
      SRC_BEYOND:    bits = ROW_EMPTY;
      SRC_FILL:      bits = at_cursor(t) ? ROW_FULL : ROW_EMPTY;
      SRC_UNDERLINE: bits = ROW_FULL;
      default: begin
        bits = glyph_mem[glyph_addr(t)];
        if (t.bold) bits = bits | (bits >> 1);
      end
    endcase
    for (int x = 0; x < GLYPH_COLS; x++) begin
      e.pixel      = bits[GLYPH_W-1-x] ? fg : bg;
      e.last_pixel = (x == GLYPH_COLS - 1);
      expected_pixels.push_back(e);
    end
  endfunction

  function automatic cell_txn_t rand_txn();
    cell_txn_t t;
    t.cmd          = CMD_W'($urandom_range(0, 3));
    t.char_code    = CODE_W'($urandom_range(0, 255));
    t.fg_index     = CIDX_W'($urandom_range(0, 15));
    t.bg_index     = CIDX_W'($urandom_range(0, 15));
    t.bold         = 1'($urandom_range(0, 1));
    t.underline    = 1'($urandom_range(0, 1));
    t.blink        = 1'($urandom_range(0, 1));
    t.column       = POS_W'($urandom_range(0, 63));
    t.line         = POS_W'($urandom_range(0, 63));
    t.row_in_cell  = ROW_W'($urandom_range(0, 15));
    t.load_address = LADDR_W'($urandom_range(0, 4095));
    t.load_value   = LVAL_W'($urandom_range(0, 65535));
    return t;
  endfunction

  function automatic cell_txn_t mk_render(logic [CODE_W-1:0] code, int row, int fg, int bg,
                                          bit bold, bit uline);
    cell_txn_t t;
    t             = rand_txn();
    t.cmd         = CMD_RENDER;
    t.char_code   = code;
    t.row_in_cell = ROW_W'(row);
    t.fg_index    = CIDX_W'(fg);
    t.bg_index    = CIDX_W'(bg);
    t.bold        = bold;
    t.underline   = uline;
    t.blink       = 1'b0;
    return t;
  endfunction

  function automatic cell_txn_t mk_load(logic [CMD_W-1:0] c, int addr, int val);
    cell_txn_t t;
    t              = rand_txn();
    t.cmd          = c;
    t.load_address = LADDR_W'(addr);
    t.load_value   = LVAL_W'(val);
    return t;
  endfunction

  // Present one transaction, hold until accepted, then update the predictor.
  task automatic send_txn(cell_txn_t t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.cmd          <= t.cmd;
    in_chan.char_code    <= t.char_code;
    in_chan.fg_index     <= t.fg_index;
    in_chan.bg_index     <= t.bg_index;
    in_chan.bold         <= t.bold;
    in_chan.underline    <= t.underline;
    in_chan.blink        <= t.blink;
    in_chan.column       <= t.column;
    in_chan.line         <= t.line;
    in_chan.row_in_cell  <= t.row_in_cell;
    in_chan.load_address <= t.load_address;
    in_chan.load_value   <= t.load_value;
    in_chan.valid        <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    case (t.cmd)
      CMD_RENDER: predict_row(t);
      CMD_LOAD_GLYPH: begin
        glyph_mem[t.load_address]     = t.load_value[GLYPH_W-1:0];
        glyph_written[t.load_address] = 1'b1;
      end
      CMD_LOAD_PAL: begin
        if (t.load_address < PALETTE_SIZE) begin
          pal_mem[t.load_address]     = t.load_value;
          pal_written[t.load_address] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Load any not yet written palette or glyph entry the row will read, then send the render.
  task automatic render_cell(cell_txn_t t);
    if (!pal_written[t.fg_index])
      send_txn(mk_load(CMD_LOAD_PAL, t.fg_index, $urandom_range(0, 65535)));
    if (!pal_written[t.bg_index])
      send_txn(mk_load(CMD_LOAD_PAL, t.bg_index, $urandom_range(0, 65535)));
    if (row_source(t) == SRC_GLYPH && !glyph_written[glyph_addr(t)])
      send_txn(mk_load(CMD_LOAD_GLYPH, glyph_addr(t), $urandom_range(0, 65535)));
    send_txn(t);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(v);
    @(posedge clk);
    case (idx)
      CFG_FIRST_CODE:     reg_first_code  = CODE_W'(v);
      CFG_LAST_CODE:      reg_last_code   = CODE_W'(v);
      CFG_CURSOR_VISIBLE: reg_cursor_on   = v[0];
      CFG_CURSOR_COLUMN:  reg_cursor_col  = POS_W'(v);
      CFG_CURSOR_LINE:    reg_cursor_line = POS_W'(v);
      CFG_BLINK_PHASE:    reg_blink_phase = v[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_rows();
    send_txn(mk_load(CMD_LOAD_PAL, 0, 16'h0000));
    send_txn(mk_load(CMD_LOAD_PAL, PALETTE_SIZE - 1, 16'hFFFF));
    send_txn(mk_load(CMD_LOAD_GLYPH, 0, 16'hFF81));
    render_cell(mk_render(FIRST_CODE_RST, 0, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(FIRST_CODE_RST, 0, 15, 0, 1'b1, 1'b0));
    send_txn(mk_load(CMD_LOAD_GLYPH,
                     (LAST_CODE_RST - FIRST_CODE_RST) * GLYPH_ROWS + GLYPH_ROWS - 1,
                     16'h003C));
    render_cell(mk_render(LAST_CODE_RST, GLYPH_ROWS - 1, 0, 15, 1'b0, 1'b0));
    render_cell(mk_render(LAST_CODE_RST, GLYPH_ROWS - 1, 0, 15, 1'b1, 1'b1));
    render_cell(mk_render(LAST_CODE_RST, GLYPH_ROWS - 2, 15, 0, 1'b1, 1'b1));
    render_cell(mk_render(CODE_W'(FIRST_CODE_RST - 1), 0, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(CODE_W'(LAST_CODE_RST + 1), 3, 15, 0, 1'b1, 1'b1));
    render_cell(mk_render(8'd65, GLYPH_ROWS, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(8'd65, 15, 0, 15, 1'b1, 1'b1));
  endtask

  task automatic test_ignored_items();
    send_txn(mk_load(CMD_UNUSED, 0, 16'hFFFF));
    send_txn(mk_load(CMD_LOAD_PAL, PALETTE_SIZE, 16'h1234));
    send_txn(mk_load(CMD_LOAD_PAL, 4095, 16'h5678));
    send_txn(mk_load(CMD_LOAD_GLYPH, GLYPH_STORE_DEPTH - 1, 16'h00A5));
    render_cell(mk_render(FIRST_CODE_RST, 0, 0, 15, 1'b0, 1'b0));
  endtask

  task automatic test_code_window();
    wait_idle();
    write_reg(CFG_FIRST_CODE, 0);
    write_reg(CFG_LAST_CODE, 255);
    render_cell(mk_render(8'd0, 0, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(8'd255, GLYPH_ROWS - 1, 15, 0, 1'b1, 1'b0));
    render_cell(mk_render(8'd255, 0, 0, 15, 1'b1, 1'b0));
    wait_idle();
    write_reg(CFG_FIRST_CODE, 255);
    write_reg(CFG_LAST_CODE, 0);
    render_cell(mk_render(8'd0, 1, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(8'd128, 2, 15, 0, 1'b1, 1'b0));
    render_cell(mk_render(8'd255, 3, 15, 0, 1'b0, 1'b1));
    wait_idle();
    write_reg(CFG_FIRST_CODE, 65);
    write_reg(CFG_LAST_CODE, 65);
    render_cell(mk_render(8'd64, 5, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(8'd65, 5, 15, 0, 1'b0, 1'b0));
    render_cell(mk_render(8'd66, 5, 15, 0, 1'b0, 1'b0));
  endtask

  task automatic test_cursor_and_blink();
    cell_txn_t t;
    wait_idle();
    write_reg(CFG_FIRST_CODE, 0);
    write_reg(CFG_LAST_CODE, 255);
    write_reg(CFG_CURSOR_VISIBLE, 1);
    write_reg(CFG_CURSOR_COLUMN, 63);
    write_reg(CFG_CURSOR_LINE, 63);
    t        = mk_render(8'd100, 4, 5, 9, 1'b0, 1'b0);
    t.column = 63;
    t.line   = 63;
    render_cell(t);
    t.blink = 1'b1;
    render_cell(t);
    wait_idle();
    write_reg(CFG_BLINK_PHASE, 1);
    render_cell(t);
    t.blink = 1'b0;
    render_cell(t);
    t.line = 62;
    render_cell(t);
    t.blink = 1'b1;
    render_cell(t);
    t.line        = 63;
    t.row_in_cell = 13;
    render_cell(t);
    wait_idle();
    write_reg(CFG_FIRST_CODE, 1);
    write_reg(CFG_CURSOR_COLUMN, 0);
    write_reg(CFG_CURSOR_LINE, 0);
    t        = mk_render(8'd0, 2, 3, 7, 1'b1, 1'b0);
    t.column = 0;
    t.line   = 0;
    render_cell(t);
    wait_idle();
    write_reg(CFG_CURSOR_VISIBLE, 0);
    render_cell(t);
    t.char_code = 8'd1;
    render_cell(t);
    wait_idle();
    write_reg(CFG_BLINK_PHASE, 0);
  endtask

  task automatic test_random_traffic();
    cell_txn_t t;
    int        pick;
    int        lo;
    int        hi;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      idle_en = (phase != RAND_PHASES - 1);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        lo = $urandom_range(0, 64);
        hi = $urandom_range(lo, 255);
      end else if (pick < 70) begin
        lo = $urandom_range(0, 255);
        hi = lo;
      end else if (pick < 85) begin
        lo = $urandom_range(1, 255);
        hi = $urandom_range(0, lo - 1);
      end else begin
        lo = 0;
        hi = 255;
      end
      write_reg(CFG_FIRST_CODE, lo);
      write_reg(CFG_LAST_CODE, hi);
      write_reg(CFG_CURSOR_VISIBLE, $urandom_range(0, 1));
      write_reg(CFG_CURSOR_COLUMN, $urandom_range(0, 63));
      write_reg(CFG_CURSOR_LINE, $urandom_range(0, 63));
      write_reg(CFG_BLINK_PHASE, int'($urandom_range(0, 2) == 0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        t    = rand_txn();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          t.cmd = CMD_LOAD_GLYPH;
          send_txn(t);
        end else if (pick < 14) begin
          t.cmd          = CMD_LOAD_PAL;
          t.load_address = LADDR_W'($urandom_range(0, 31));
          send_txn(t);
        end else if (pick < 18) begin
          t.cmd = CMD_UNUSED;
          send_txn(t);
        end else begin
          t.cmd = CMD_RENDER;
          if (lo <= hi && $urandom_range(0, 6) != 0) t.char_code = CODE_W'($urandom_range(lo, hi));
          pick = $urandom_range(0, 19);
          if (pick < 3) t.row_in_cell = ROW_W'(GLYPH_ROWS - 1);
          else if (pick >= 5) t.row_in_cell = ROW_W'($urandom_range(0, GLYPH_ROWS - 1));
          if ($urandom_range(0, 7) == 0) begin
            t.column = reg_cursor_col;
            t.line   = reg_cursor_line;
          end
          render_cell(t);
        end
      end
    end
  endtask

  initial begin : sink_pacing
    out_chan.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_exp_t e;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", out_chan.pixel));
      end else begin
        e = expected_pixels.pop_front();
        if (out_chan.pixel !== e.pixel)
          report_mismatch($sformatf("pixel got %h expected %h", out_chan.pixel, e.pixel));
        if (out_chan.last_pixel !== e.last_pixel)
          report_mismatch($sformatf("last_pixel got %b expected %b",
                                    out_chan.last_pixel, e.last_pixel));
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FIRST_CODE;
    cfg_wdata <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.cmd          <= CMD_RENDER;
    in_chan.char_code    <= '0;
    in_chan.fg_index     <= '0;
    in_chan.bg_index     <= '0;
    in_chan.bold         <= 1'b0;
    in_chan.underline    <= 1'b0;
    in_chan.blink        <= 1'b0;
    in_chan.column       <= '0;
    in_chan.line         <= '0;
    in_chan.row_in_cell  <= '0;
    in_chan.load_address <= '0;
    in_chan.load_value   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_rows();
    test_ignored_items();
    test_code_window();
    test_cursor_and_blink();
    test_random_traffic();
    in_chan.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
